// ===== design/rvdiv_pkg.sv =====
// Shared types, widths and a helper function of the 64-bit integer divide unit.
`default_nettype none

package rvdiv_pkg;

  // Operating widths
  localparam int unsigned XLEN = 64;
  localparam int unsigned WLEN = 32;
  // Step counter holds the full step count
  localparam int unsigned CntW = $clog2(XLEN + 1);

  // Input beat
  typedef struct packed {
    logic [XLEN-1:0] dividend;
    logic [XLEN-1:0] divisor;
    logic            is_unsigned;
    logic            word_mode;
    logic            enable;
  } rvdiv_in_t;

  // Output beat
  typedef struct packed {
    logic [XLEN-1:0] quotient;
    logic [XLEN-1:0] remainder;
  } rvdiv_out_t;

  // Per-operation control carried from operand prep to result fix-up
  typedef struct packed {
    logic enable;
    logic is_unsigned;
    logic word_mode;
    logic neg_quo;
    logic neg_rem;
    logic div_zero;
  } rvdiv_ctl_t;

  // Sign-extend the low word to full width
  function automatic logic [XLEN-1:0] sext_word(input logic [XLEN-1:0] v);
    sext_word = {{(XLEN-WLEN){v[WLEN-1]}}, v[WLEN-1:0]};
  endfunction

endpackage

`default_nettype wire

// ===== design/rvdiv_prep.sv =====
// Operand preparation: word extension, sign detection and magnitudes.
`default_nettype none

module rvdiv_prep
  import rvdiv_pkg::*;
(
  input  rvdiv_in_t        in_i,
  output rvdiv_ctl_t       ctl_o,
  output logic [XLEN-1:0]  dividend_mag_o,
  output logic [XLEN-1:0]  divisor_mag_o
);

  logic [XLEN-1:0] a_ext;
  logic [XLEN-1:0] b_ext;
  logic            a_neg;
  logic            b_neg;

  // Word mode takes the low word, zero- or sign-extended
  always_comb begin
    if (in_i.word_mode) begin
      if (in_i.is_unsigned) begin
        a_ext = {{(XLEN-WLEN){1'b0}}, in_i.dividend[WLEN-1:0]};
        b_ext = {{(XLEN-WLEN){1'b0}}, in_i.divisor[WLEN-1:0]};
      end else begin
        a_ext = sext_word(in_i.dividend);
        b_ext = sext_word(in_i.divisor);
      end
    end else begin
      a_ext = in_i.dividend;
      b_ext = in_i.divisor;
    end
  end

  assign a_neg = ~in_i.is_unsigned & a_ext[XLEN-1];
  assign b_neg = ~in_i.is_unsigned & b_ext[XLEN-1];

  // Magnitudes; the most negative value maps onto itself, read as unsigned
  assign dividend_mag_o = a_neg ? XLEN'(~a_ext + 1'b1) : a_ext;
  assign divisor_mag_o  = b_neg ? XLEN'(~b_ext + 1'b1) : b_ext;

  always_comb begin
    ctl_o.enable      = in_i.enable;
    ctl_o.is_unsigned = in_i.is_unsigned;
    ctl_o.word_mode   = in_i.word_mode;
    ctl_o.neg_quo     = a_neg ^ b_neg;
    ctl_o.neg_rem     = a_neg;
    ctl_o.div_zero    = (b_ext == '0);
  end

endmodule

`default_nettype wire

// ===== design/rvdiv_core.sv =====
// Bit-serial restoring divider: one quotient bit per cycle on unsigned magnitudes.
`default_nettype none

module rvdiv_core
  import rvdiv_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             word_i,
  input  logic [XLEN-1:0]  dividend_i,
  input  logic [XLEN-1:0]  divisor_i,
  output logic             done_o,
  output logic [XLEN-1:0]  quotient_o,
  output logic [XLEN-1:0]  remainder_o
);

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [XLEN-1:0] quo_q, quo_d;
  logic [XLEN-1:0] rem_q, rem_d;
  logic [XLEN-1:0] dvs_q;
  logic [XLEN:0]   part;
  logic [XLEN+1:0] diff;
  logic            borrow;

  // Shift in the next dividend bit and try the subtract
  assign part   = {rem_q, quo_q[XLEN-1]};
  assign diff   = {1'b0, part} - {2'b00, dvs_q};
  assign borrow = diff[XLEN+1];

  always_comb begin
    rem_d = borrow ? part[XLEN-1:0] : diff[XLEN-1:0];
    quo_d = {quo_q[XLEN-2:0], ~borrow};
  end

  // Last step is under way
  assign done_o = busy_q && (cnt_q == CntW'(1));

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= word_i ? CntW'(WLEN) : CntW'(XLEN);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (done_o) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath shift registers; word operands start at the top so 32 steps suffice
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= word_i ? {dividend_i[WLEN-1:0], {(XLEN-WLEN){1'b0}}} : dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

// ===== design/rvdiv_fix.sv =====
// Result fix-up: sign restore, word extension and zero-divisor override.
`default_nettype none

module rvdiv_fix
  import rvdiv_pkg::*;
(
  input  rvdiv_ctl_t       ctl_i,
  input  logic [XLEN-1:0]  quotient_i,
  input  logic [XLEN-1:0]  remainder_i,
  output rvdiv_out_t       res_o
);

  logic [XLEN-1:0] quo_s;
  logic [XLEN-1:0] rem_s;

  assign quo_s = ctl_i.neg_quo ? XLEN'(~quotient_i + 1'b1) : quotient_i;
  assign rem_s = ctl_i.neg_rem ? XLEN'(~remainder_i + 1'b1) : remainder_i;

  // Unsigned word results are already zero-extended by the core
  always_comb begin
    if (ctl_i.div_zero) begin
      res_o.quotient  = '0;
      res_o.remainder = '0;
    end else if (ctl_i.word_mode && !ctl_i.is_unsigned) begin
      res_o.quotient  = sext_word(quo_s);
      res_o.remainder = sext_word(rem_s);
    end else begin
      res_o.quotient  = quo_s;
      res_o.remainder = rem_s;
    end
  end

endmodule

`default_nettype wire

// ===== design/integer_divider_rv64.sv =====
// Top level of the 64/32-bit signed and unsigned integer divide unit.
// Each operation runs the bit-serial divider, one quotient bit per cycle,
// then the result fix-up into the output register, which waits while the
// output is stalled; enable low skips the divider (held results are sent
// again). A new input beat is taken only once the last result is loaded.
// Reset: asynchronous active low; clears state, output valid and the held results to zero.
`default_nettype none

module integer_divider_rv64
  import rvdiv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  rvdiv_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output rvdiv_out_t out_data_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIX  = 2'd2;

  logic [1:0]      state_q, state_d;
  rvdiv_ctl_t      ctl_q;
  rvdiv_ctl_t      prep_ctl;
  logic [XLEN-1:0] dividend_mag;
  logic [XLEN-1:0] divisor_mag;
  logic            in_fire;
  logic            core_start;
  logic            core_done;
  logic [XLEN-1:0] core_quo;
  logic [XLEN-1:0] core_rem;
  rvdiv_out_t      fix_res;
  rvdiv_out_t      held_q;
  rvdiv_out_t      out_q;
  logic            out_valid_q;
  logic            out_free;
  logic            out_load;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign core_start = in_fire & in_data_i.enable;
  assign out_free   = ~out_valid_q | out_ready_i;
  assign out_load   = (state_q == ST_FIX) & out_free;

  rvdiv_prep u_prep (
    .in_i           (in_data_i),
    .ctl_o          (prep_ctl),
    .dividend_mag_o (dividend_mag),
    .divisor_mag_o  (divisor_mag)
  );

  rvdiv_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (core_start),
    .word_i      (in_data_i.word_mode),
    .dividend_i  (dividend_mag),
    .divisor_i   (divisor_mag),
    .done_o      (core_done),
    .quotient_o  (core_quo),
    .remainder_o (core_rem)
  );

  rvdiv_fix u_fix (
    .ctl_i       (ctl_q),
    .quotient_i  (core_quo),
    .remainder_i (core_rem),
    .res_o       (fix_res)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = in_data_i.enable ? ST_RUN : ST_FIX;
        end
      end
      ST_RUN: begin
        if (core_done) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      held_q      <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
        if (ctl_q.enable) begin
          held_q <= fix_res;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Operation control and output beat payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ctl_q <= prep_ctl;
    end
    if (out_load) begin
      out_q <= ctl_q.enable ? fix_res : held_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== design/rvdiv_checker.sv =====
// Port-level checks of the divide unit and their binding to the top level.
`default_nettype none

module rvdiv_checker
  import rvdiv_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input rvdiv_out_t out_data_o
);

  // A stalled output beat stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  // A stalled output beat keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  // One item at a time: an accepted beat closes the input side
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while an item is in flight");

  // A new result appears only from the busy phase, never straight from idle
  a_out_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o) |-> !$past(in_ready_o))
    else $error("output beat appeared without a finished item");

  // After an accepted beat, no new result appears straight after the input side was open
  a_in_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> ##1 !(out_valid_o && !$past(out_valid_o) &&
      $past(in_ready_o)))
    else $error("output beat raised while input side open");

endmodule

bind integer_divider_rv64 rvdiv_checker u_rvdiv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the integer_divider_rv64 divide unit.
`timescale 1ns / 100ps

module tb_top;
  import rvdiv_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int unsigned QUIET_LIMIT  = 5000;  // cycles with no beat before giving up
  localparam int unsigned DRAIN_CYCLES = 70;    // settle time after the drain, longer than a 64-bit divide
  localparam int unsigned MAX_REPORTS  = 10;

  // Predicts quotient/remainder beats and checks them in order
  class quot_rem_scoreboard;
    logic [XLEN-1:0] held_quo;
    logic [XLEN-1:0] held_rem;
    rvdiv_out_t      expected_qr[$];
    int unsigned     mismatches;

    function new();
      held_quo    = '0;
      held_rem    = '0;
      mismatches  = 0;
    endfunction

    // Truncating divide, remainder follows dividend sign; updates the held pair
    function void divide(rvdiv_in_t b);
      logic [XLEN-1:0] num, den, mag_num, mag_den, quo, rem;
      logic            neg_num, neg_den;
      num = b.dividend;
      den = b.divisor;
      if (b.word_mode) begin
        if (b.is_unsigned) begin
          num = {{(XLEN-WLEN){1'b0}}, num[WLEN-1:0]};
          den = {{(XLEN-WLEN){1'b0}}, den[WLEN-1:0]};
        end else begin
          num = {{(XLEN-WLEN){num[WLEN-1]}}, num[WLEN-1:0]};
          den = {{(XLEN-WLEN){den[WLEN-1]}}, den[WLEN-1:0]};
        end
      end
      if (den == '0) begin
        quo = '0;
        rem = '0;
      end else if (b.is_unsigned) begin
        quo = num / den;
        rem = num % den;
      end else begin
        neg_num = num[XLEN-1];
        neg_den = den[XLEN-1];
        mag_num = neg_num ? ('0 - num) : num;
        mag_den = neg_den ? ('0 - den) : den;
        quo = mag_num / mag_den;
        rem = mag_num % mag_den;
        if (neg_num != neg_den) quo = '0 - quo;
        if (neg_num) rem = '0 - rem;
        // word results re-extend from bit 31; this also folds word overflow
        if (b.word_mode) begin
          quo = {{(XLEN-WLEN){quo[WLEN-1]}}, quo[WLEN-1:0]};
          rem = {{(XLEN-WLEN){rem[WLEN-1]}}, rem[WLEN-1:0]};
        end
      end
      held_quo = quo;
      held_rem = rem;
    endfunction

    function void note_operands(rvdiv_in_t b);
      rvdiv_out_t e;
      if (b.enable) divide(b);
      e.quotient  = held_quo;
      e.remainder = held_rem;
      expected_qr.push_back(e);
    endfunction

    function void report(string field, logic [XLEN-1:0] exp_v, logic [XLEN-1:0] got_v);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %h, got %h", $realtime, field, exp_v, got_v);
    endfunction

    function void check_result(rvdiv_out_t got);
      rvdiv_out_t e;
      if (expected_qr.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result beat with nothing pending: quotient %h remainder %h",
                   $realtime, got.quotient, got.remainder);
        return;
      end
      e = expected_qr.pop_front();
      if (got.quotient !== e.quotient) report("quotient", e.quotient, got.quotient);
      if (got.remainder !== e.remainder) report("remainder", e.remainder, got.remainder);
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  rvdiv_in_t  in_data_i;
  logic       out_valid_o;
  logic       out_ready_i;
  rvdiv_out_t out_data_o;

  quot_rem_scoreboard sb = new();

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_left;

  integer_divider_rv64 dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Receiver: random stalls plus one long hold-off
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left   = hold_left - 1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  // Watchdog: too long without any beat on either side
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Offer one beat, with random idle cycles first; returns at a falling edge
  task automatic send_beat(input rvdiv_in_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_operands(b);
    @(negedge clk_i);
  endtask

  // Sender goes quiet until every pending result has been seen
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.expected_qr.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic rvdiv_in_t make_beat(logic [63:0] num, logic [63:0] den,
                                          logic uns, logic word, logic en);
    rvdiv_in_t b;
    b.dividend    = num;
    b.divisor     = den;
    b.is_unsigned = uns;
    b.word_mode   = word;
    b.enable      = en;
    return b;
  endfunction

  // Operand mix: full range, shifted, tiny, word-sized, edge values, powers of two
  function automatic logic [63:0] pick_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(5))
      0: ;
      1: v = v >> $urandom_range(63);
      2: v = {{60{v[63]}}, v[3:0]};
      3: v = {{32{v[31]}}, v[31:0]};
      4: begin
        case ($urandom_range(5))
          0: v = 64'h8000_0000_0000_0000;
          1: v = 64'h7FFF_FFFF_FFFF_FFFF;
          2: v = '1;
          3: v[31:0] = 32'h8000_0000;
          4: v[31:0] = 32'hFFFF_FFFF;
          default: v[31:0] = 32'h0;
        endcase
      end
      default: v = 64'd1 << $urandom_range(63);
    endcase
    return v;
  endfunction

  task automatic run_random(input int unsigned n, input int unsigned s_pct,
                            input int unsigned r_pct);
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    repeat (n)
      send_beat(make_beat(pick_operand(), pick_operand(), 1'($urandom_range(1)),
                          1'($urandom_range(1)), $urandom_range(9) != 0));
  endtask

  initial begin
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: hold after reset, extremes, sign combos, overflow, zero divisor
    send_beat(make_beat(64'h1234, 64'h5, 1'b1, 1'b0, 1'b0));
    send_beat(make_beat('1, 64'h1, 1'b1, 1'b0, 1'b1));
    send_beat(make_beat('1, '1, 1'b1, 1'b0, 1'b1));
    send_beat(make_beat(64'd100, 64'd7, 1'b1, 1'b0, 1'b1));
    send_beat(make_beat(-64'sd7, 64'd2, 1'b0, 1'b0, 1'b1));
    send_beat(make_beat(64'd7, -64'sd2, 1'b0, 1'b0, 1'b1));
    send_beat(make_beat(-64'sd7, -64'sd2, 1'b0, 1'b0, 1'b1));
    send_beat(make_beat(64'h8000_0000_0000_0000, '1, 1'b0, 1'b0, 1'b1));
    send_beat(make_beat(64'h8000_0000_0000_0000, 64'd1, 1'b0, 1'b0, 1'b1));
    send_beat(make_beat(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 1'b0, 1'b0, 1'b1));
    send_beat(make_beat('1, '1, 1'b0, 1'b0, 1'b0));
    send_beat(make_beat(-64'sd5, 64'd0, 1'b0, 1'b0, 1'b1));
    send_beat(make_beat('1, 64'd0, 1'b1, 1'b0, 1'b1));
    send_beat(make_beat(64'd0, '1, 1'b1, 1'b0, 1'b1));
    send_beat(make_beat(64'hA5A5_A5A5_FFFF_FFFF, 64'h5A5A_5A5A_0000_0003, 1'b1, 1'b1, 1'b1));
    send_beat(make_beat(64'h0000_0000_8000_0000, 64'h1234_5678_FFFF_FFFF, 1'b0, 1'b1, 1'b1));
    send_beat(make_beat(64'h0F0F_0F0F_FFFF_FFF9, 64'hF0F0_F0F0_0000_0002, 1'b0, 1'b1, 1'b1));
    send_beat(make_beat(64'h0, 64'h0, 1'b1, 1'b1, 1'b0));
    send_beat(make_beat(64'h0000_0000_7FFF_FFFF, 64'hDEAD_BEEF_0000_0000, 1'b0, 1'b1, 1'b1));
    send_beat(make_beat(64'hFFFF_FFFF_FFFF_FFFF, 64'hDEAD_BEEF_0000_0000, 1'b1, 1'b1, 1'b1));
    send_beat(make_beat(64'h0000_0000_7FFF_FFFF, 64'h0000_0000_8000_0000, 1'b0, 1'b1, 1'b1));
    send_beat(make_beat(64'h0000_0000_FFFF_FFFF, 64'h0000_0000_8000_0000, 1'b1, 1'b1, 1'b1));
    send_beat(make_beat('1, 64'h8000_0000_0000_0000, 1'b0, 1'b1, 1'b0));

    // No idling, with a long receiver hold-off so the input backs up
    hold_left = HOLD_CYCLES;
    run_random(175, 0, 0);
    wait_drained();
    run_random(175, 61, 0);
    wait_drained();
    run_random(175, 0, 61);
    run_random(175, 10, 10);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_qr.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
